FILE: hdl/bcm_pkg.sv
// Package for the banked cartridge mapper: sizes, codes, register indexes
// and the structs passed between the mapper modules. No dependencies.
`timescale 1ns / 1ps

package bcm_pkg;

    localparam int PAGE_BYTES = 16384;
    localparam int PAGE_LIMIT = 32;
    localparam int RAM_BYTES  = 16384;

    localparam int RAM_AW     = $clog2(RAM_BYTES);
    localparam int OFFSET_W   = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = 5;
    localparam int NPAGE_W    = 6;
    localparam int NRAM_W     = 15;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_ADDR_W = 19;
    localparam int STATUS_W   = 3;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam int MOD_STEPS  = DATA_W;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

    localparam logic [ADDR_W-1:0]  CTRL_ADDR       = 16'hFFFC;
    localparam logic [1:0]         RAM_WINDOW_SLOT = 2'b10;
    localparam logic [1:0]         FIXED_SLOT      = 2'b11;
    localparam logic [PAGE_W-1:0]  FIXED_SLOT_PAGE = 5'd3;
    localparam int                 RAM_ENABLE_BIT  = 3;
    localparam int                 RAM_WRITE_BIT   = 2;
    localparam logic [DATA_W-1:0]  OPEN_BUS_BYTE   = 8'hFF;
    localparam logic [NPAGE_W-1:0] ROM_PAGES_RESET = 6'd32;
    localparam logic [NRAM_W-1:0]  RAM_COUNT_RESET = 15'd16384;

    // Register index as carried by paddr[2]
    localparam logic REG_ROM_PAGE_COUNT = 1'b0;
    localparam logic REG_RAM_BYTE_COUNT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ROM_READ      = 3'd0,
        ST_RAM_READ      = 3'd1,
        ST_OPEN_BUS      = 3'd2,
        ST_CTRL_WRITE    = 3'd3,
        ST_RAM_WRITE     = 3'd4,
        ST_WRITE_IGNORED = 3'd5
    } access_status_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [NPAGE_W-1:0] npages;
        logic [NRAM_W-1:0]  nram;
    } bcm_cfg_t;

    typedef struct packed {
        logic               start;
        logic [DATA_W-1:0]  dividend;
        logic [NPAGE_W-1:0] divisor;
    } bcm_mod_req_t;

    typedef struct packed {
        logic               done;
        logic [NPAGE_W-1:0] rem;
    } bcm_mod_resp_t;

endpackage

FILE: hdl/bcm_channels.sv
// Valid/ready channel interfaces for mapper bus items and result items.
// Depends on bcm_pkg.
`timescale 1ns / 1ps

interface bcm_in_if;
    import bcm_pkg::*;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] write_byte;

    modport source (output valid, req_type, bus_address, write_byte, input ready);
    modport sink   (input valid, req_type, bus_address, write_byte, output ready);
endinterface

interface bcm_out_if;
    import bcm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [DATA_W-1:0]     read_byte;
    logic [ROM_ADDR_W-1:0] rom_byte_address;
    logic [STATUS_W-1:0]   access_status;

    modport source (output valid, read_byte, rom_byte_address, access_status, input ready);
    modport sink   (input valid, read_byte, rom_byte_address, access_status, output ready);
endinterface

FILE: hdl/bcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/bcm_mod.sv
// Iterative remainder unit: one restoring step per cycle over the dividend.
// Depends on bcm_pkg.
`timescale 1ns / 1ps

module bcm_mod (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bcm_pkg::bcm_mod_req_t  req,
    output bcm_pkg::bcm_mod_resp_t resp
);
    import bcm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    dvd_reg, dvd_next;
    logic [NPAGE_W-1:0]   dvs_reg, dvs_next;
    logic [NPAGE_W-1:0]   rem_reg, rem_next;
    logic [NPAGE_W:0]     trial;
    logic [NPAGE_W:0]     trial_sub;

    // Bring down the next dividend bit, subtract when it fits
    assign trial     = {rem_reg, dvd_reg[DATA_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, dvs_reg}) ? trial_sub[NPAGE_W-1:0]
                                                  : trial[NPAGE_W-1:0];
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign resp.done = done_reg;
    assign resp.rem  = rem_reg;

endmodule

FILE: hdl/bcm_cfg.sv
// APB configuration registers of the mapper, with clamped effective values.
// Depends on bcm_pkg.
`timescale 1ns / 1ps

module bcm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcm_pkg::PADDR_W-1:0] paddr,
    input  logic [bcm_pkg::PDATA_W-1:0] pwdata,
    output logic [bcm_pkg::PDATA_W-1:0] prdata,
    output bcm_pkg::bcm_cfg_t           cfg
);
    import bcm_pkg::*;

    logic [NPAGE_W-1:0] rom_pages_reg, rom_pages_next;
    logic [NRAM_W-1:0]  ram_count_reg, ram_count_next;
    logic               wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        rom_pages_next = rom_pages_reg;
        ram_count_next = ram_count_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_ROM_PAGE_COUNT: rom_pages_next = pwdata[NPAGE_W-1:0];
                REG_RAM_BYTE_COUNT: ram_count_next = pwdata[NRAM_W-1:0];
                default:            rom_pages_next = rom_pages_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_pages_reg <= ROM_PAGES_RESET;
            ram_count_reg <= RAM_COUNT_RESET;
        end
        else
        begin
            rom_pages_reg <= rom_pages_next;
            ram_count_reg <= ram_count_next;
        end
    end

    assign prdata = (paddr[2] == REG_RAM_BYTE_COUNT)
                  ? {{(PDATA_W-NRAM_W){1'b0}}, ram_count_reg}
                  : {{(PDATA_W-NPAGE_W){1'b0}}, rom_pages_reg};

    // Cap at what the cartridge can hold
    assign cfg.npages = (rom_pages_reg > NPAGE_W'(PAGE_LIMIT)) ? NPAGE_W'(PAGE_LIMIT)
                                                               : rom_pages_reg;
    assign cfg.nram   = (ram_count_reg > NRAM_W'(RAM_BYTES)) ? NRAM_W'(RAM_BYTES)
                                                             : ram_count_reg;

endmodule

FILE: hdl/banked_cartridge_mapper_core.sv
// Path from accept to result: control, ignored and open-bus items pass S_EXEC and
// S_DONE, cartridge RAM reads S_EXEC, S_RAM_RD, S_RAM_DATA and S_DONE, ROM reads and
// page writes S_EXEC, S_MOD (8-step remainder unit) and S_DONE. One item at a time:
// the next is taken the cycle after the previous result enters the output register,
// and that register waits out any stall of the output.
// Reset: async active low; pages 0,1,2, RAM off, no clearing pass (RAM undefined).
`timescale 1ns / 1ps

module banked_cartridge_mapper_core (
    input  logic                        clk,
    input  logic                        rst_n,
    bcm_in_if.sink                      in_ch,
    bcm_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcm_pkg::PADDR_W-1:0] paddr,
    input  logic [bcm_pkg::PDATA_W-1:0] pwdata,
    output logic [bcm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import bcm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_EXEC     = 6'b000010,
        S_MOD      = 6'b000100,
        S_RAM_RD   = 6'b001000,
        S_RAM_DATA = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Item held while it is worked on
    logic                  is_write_reg, is_write_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [DATA_W-1:0]     data_reg, data_next;

    // Result under construction
    logic [DATA_W-1:0]     res_byte_reg, res_byte_next;
    logic [ROM_ADDR_W-1:0] res_addr_reg, res_addr_next;
    access_status_t        res_status_reg, res_status_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     out_byte_reg, out_byte_next;
    logic [ROM_ADDR_W-1:0] out_addr_reg, out_addr_next;
    access_status_t        out_status_reg, out_status_next;

    // Mapper control state
    logic [PAGE_W-1:0]     slot_page_reg [3];
    logic [PAGE_W-1:0]     slot_page_next [3];
    logic                  ram_on_reg, ram_on_next;
    logic                  ram_wr_on_reg, ram_wr_on_next;

    bcm_cfg_t              cfg;
    bcm_mod_req_t          mod_req;
    bcm_mod_resp_t         mod_resp;

    logic                  ram_we;
    logic                  ram_re;
    logic [DATA_W-1:0]     ram_rdata;

    logic [OFFSET_W-1:0]   offset;
    logic                  in_window;
    logic                  ram_hit;
    logic                  no_rom;
    logic [PAGE_W-1:0]     read_page;
    logic [1:0]            slot_idx;
    logic                  in_fire;
    logic                  out_take;

    bcm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bcm_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .resp  (mod_resp)
    );

    // Cartridge RAM, bank 0 only: offset is the low 14 address bits
    bcm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_BYTES)
    ) u_cart_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (offset[RAM_AW-1:0]),
        .wdata (data_reg),
        .re    (ram_re),
        .raddr (offset[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign pready   = 1'b1;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_take = out_valid_reg && out_ch.ready;

    // Decode of the held item
    assign offset    = addr_reg[OFFSET_W-1:0];
    assign in_window = (addr_reg[ADDR_W-1:ADDR_W-2] == RAM_WINDOW_SLOT);
    assign ram_hit   = ({1'b0, offset} < cfg.nram);
    assign no_rom    = (cfg.npages == '0);
    // Page-select registers FFFD..FFFF map to slots 0..2
    assign slot_idx  = addr_reg[1:0] - 2'd1;

    // Slot three is hardwired to page 3
    always_comb
    begin
        unique case (addr_reg[ADDR_W-1:ADDR_W-2])
            2'b00:      read_page = slot_page_reg[0];
            2'b01:      read_page = slot_page_reg[1];
            2'b10:      read_page = slot_page_reg[2];
            FIXED_SLOT: read_page = FIXED_SLOT_PAGE;
            default:    read_page = FIXED_SLOT_PAGE;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        is_write_next   = is_write_reg;
        addr_next       = addr_reg;
        data_next       = data_reg;
        res_byte_next   = res_byte_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        slot_page_next  = slot_page_reg;
        ram_on_next     = ram_on_reg;
        ram_wr_on_next  = ram_wr_on_reg;
        mod_req         = '0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        // Drop the output item once the sink takes it
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // Capture the bus item
                if (in_fire)
                begin
                    is_write_next = in_ch.req_type;
                    addr_next     = in_ch.bus_address;
                    data_next     = in_ch.write_byte;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_byte_next = OPEN_BUS_BYTE;
                res_addr_next = '0;
                state_next    = S_DONE;
                if (!is_write_reg)
                begin
                    if (no_rom)
                    begin
                        res_status_next = ST_OPEN_BUS;
                    end
                    else if (in_window && ram_on_reg)
                    begin
                        // RAM read, or open bus past the fitted RAM size
                        if (ram_hit)
                        begin
                            state_next = S_RAM_RD;
                        end
                        else
                        begin
                            res_status_next = ST_OPEN_BUS;
                        end
                    end
                    else
                    begin
                        // ROM read: reduce the slot page by the page count
                        mod_req.start    = 1'b1;
                        mod_req.dividend = {{(DATA_W-PAGE_W){1'b0}}, read_page};
                        mod_req.divisor  = cfg.npages;
                        state_next       = S_MOD;
                    end
                end
                else if (addr_reg >= CTRL_ADDR)
                begin
                    if (addr_reg == CTRL_ADDR)
                    begin
                        ram_on_next     = data_reg[RAM_ENABLE_BIT];
                        ram_wr_on_next  = data_reg[RAM_WRITE_BIT];
                        res_status_next = ST_CTRL_WRITE;
                    end
                    else if (no_rom)
                    begin
                        res_status_next = ST_WRITE_IGNORED;
                    end
                    else
                    begin
                        // Page select: store the byte modulo the page count
                        mod_req.start    = 1'b1;
                        mod_req.dividend = data_reg;
                        mod_req.divisor  = cfg.npages;
                        state_next       = S_MOD;
                    end
                end
                else if (in_window && ram_on_reg && ram_wr_on_reg && ram_hit)
                begin
                    ram_we          = 1'b1;
                    res_status_next = ST_RAM_WRITE;
                end
                else
                begin
                    res_status_next = ST_WRITE_IGNORED;
                end
            end

            S_MOD:
            begin
                // Hold until the remainder unit finishes
                if (mod_resp.done)
                begin
                    if (is_write_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (slot_idx == 2'(i))
                            begin
                                slot_page_next[i] = mod_resp.rem[PAGE_W-1:0];
                            end
                        end
                        res_status_next = ST_CTRL_WRITE;
                    end
                    else
                    begin
                        res_addr_next   = {mod_resp.rem[PAGE_W-1:0], offset};
                        res_status_next = ST_ROM_READ;
                    end
                    state_next = S_DONE;
                end
            end

            S_RAM_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_RAM_DATA;
            end

            S_RAM_DATA:
            begin
                res_byte_next   = ram_rdata;
                res_status_next = ST_RAM_READ;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                // Advance into the output register once it is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = res_byte_reg;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            slot_page_reg[0] <= PAGE_W'(0);
            slot_page_reg[1] <= PAGE_W'(1);
            slot_page_reg[2] <= PAGE_W'(2);
            ram_on_reg       <= 1'b0;
            ram_wr_on_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            slot_page_reg <= slot_page_next;
            ram_on_reg    <= ram_on_next;
            ram_wr_on_reg <= ram_wr_on_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_write_reg   <= is_write_next;
        addr_reg       <= addr_next;
        data_reg       <= data_next;
        res_byte_reg   <= res_byte_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_byte_reg   <= out_byte_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign in_ch.ready             = (state_reg == S_IDLE);
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.read_byte        = out_byte_reg;
    assign out_ch.rom_byte_address = out_addr_reg;
    assign out_ch.access_status    = out_status_reg;

endmodule

FILE: hdl/bcm_checker.sv
// Port-level assertions for the mapper core, attached by a bind statement.
// Depends on bcm_pkg and banked_cartridge_mapper_core.
`timescale 1ns / 1ps

module bcm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [bcm_pkg::DATA_W-1:0]     read_byte,
    input logic [bcm_pkg::ROM_ADDR_W-1:0] rom_byte_address,
    input logic [bcm_pkg::STATUS_W-1:0]   access_status,
    input logic                           pready
);
    import bcm_pkg::*;

    // Hold a result item until the sink takes it
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped before it was taken");

    // One item at a time: ready drops right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (access_status <= ST_WRITE_IGNORED))
        else $error("access status out of range");

    // Only ROM reads carry an address, only RAM reads carry data
    a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((access_status == ST_ROM_READ) || (rom_byte_address == '0))
                   && ((access_status == ST_RAM_READ) || (read_byte == OPEN_BUS_BYTE)))
        else $error("result fields do not match access status");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind banked_cartridge_mapper_core bcm_checker u_bcm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .read_byte        (out_ch.read_byte),
    .rom_byte_address (out_ch.rom_byte_address),
    .access_status    (out_ch.access_status),
    .pready           (pready)
);
